// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked at the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/fcsa_pkg.sv =====
package fcsa_pkg;

  localparam int COUNT_W  = 5;
  localparam int START_W  = 4;
  localparam int TICKET_W = 8;
  localparam int POS_W    = 4;

  localparam logic FUNC_RESERVE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    KIND_GRANT    = 2'd0,
    KIND_QUEUED   = 2'd1,
    KIND_REJECTED = 2'd2,
    KIND_RELEASED = 2'd3
  } kind_t;

endpackage

// ===== design/fcsa_req_if.sv =====
interface fcsa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [fcsa_pkg::COUNT_W-1:0]  count;
  logic [fcsa_pkg::START_W-1:0]  start_req;

  modport source (output valid, output func, output count, output start_req, input ready);
  modport sink (input valid, input func, input count, input start_req, output ready);
endinterface

// ===== design/fcsa_rsp_if.sv =====
interface fcsa_rsp_if;
  logic                          valid;
  logic                          ready;
  fcsa_pkg::kind_t               kind;
  logic [fcsa_pkg::TICKET_W-1:0] ticket;
  logic [fcsa_pkg::POS_W-1:0]    position;
  logic                          last;

  modport source (output valid, output kind, output ticket, output position, output last,
                  input ready);
  modport sink (input valid, input kind, input ticket, input position, input last,
                output ready);
endinterface

// ===== design/fifo_contiguous_slot_allocator_top.sv =====
// A reserve that joins the queue offers its one result after the head check with size
// read, the search load, five search steps, the decision and the output load. A rejected
// reserve goes straight from acceptance to the output load. A new request is taken only
// in IDLE, once the last result of the one before is in the output register; a release
// runs check, search and decision per drained grant, and again if the head stays blocked.
// Reset (rst, synchronous, active high) frees all slots, empties the wait queue and
// zeroes both ticket counters; the wait-size memory itself is not cleared.
module fifo_contiguous_slot_allocator_top #(
  parameter int SLOTS  = 16,
  parameter int QDEPTH = 8
) (
  input logic        clk,
  input logic        rst,
  fcsa_req_if.sink   req,
  fcsa_rsp_if.source rsp
);

  // Widths derived from the pool size and the queue depth.
  localparam int PIDX_W = $clog2(SLOTS);
  localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int FILL_W = $clog2(QDEPTH + 1);
  localparam int PEXT_W = (PIDX_W > fcsa_pkg::POS_W) ? PIDX_W : fcsa_pkg::POS_W;
  localparam int CNT_W  = fcsa_pkg::COUNT_W;
  localparam int STEP_W = $clog2(CNT_W);

  // The sequencer. CHECK reads the queue head's size from memory, LOAD seeds the
  // window search, SCAN runs one bit of the size per cycle, FIND decides on a grant
  // and FLUSH hands the final result of a request to the output register.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_FIND  = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  state_t state;

  // Allocator state. A set bit of occ marks a slot in use.
  logic [SLOTS-1:0]              occ;
  logic [QIDX_W-1:0]             head;
  logic [QIDX_W-1:0]             tail;
  logic [FILL_W-1:0]             fill;
  logic [fcsa_pkg::TICKET_W-1:0] next_ticket;
  logic [fcsa_pkg::TICKET_W-1:0] served_ticket;

  // Run sizes of waiting requests, one entry per queue place.
  logic [CNT_W-1:0] wait_sizes [QDEPTH];
  logic [CNT_W-1:0] size_rdata;
  logic             size_we;
  logic             size_re;

  // Request being worked on.
  logic                          is_rel;
  logic [fcsa_pkg::TICKET_W-1:0] mine;

  // Window search. After k steps, bit s of win is set when the slots from s up to,
  // but not including, s plus the low k bits of len are free, and bit s of pw is set
  // when the 2**k slots from s onward are free. Bits past the pool read as occupied.
  logic [CNT_W-1:0]  len;
  logic [STEP_W-1:0] step;
  logic [SLOTS-1:0]  win;
  logic [SLOTS-1:0]  pw;
  logic [CNT_W-1:0]  win_shift;
  logic [CNT_W-1:0]  pw_shift;

  // A result that waits until it is known whether another one follows it.
  fcsa_pkg::kind_t               held_kind;
  logic [fcsa_pkg::TICKET_W-1:0] held_ticket;
  logic [PIDX_W-1:0]             held_pos;

  // Output register.
  logic                          rsp_valid;
  fcsa_pkg::kind_t               rsp_kind;
  logic [fcsa_pkg::TICKET_W-1:0] rsp_ticket;
  logic [fcsa_pkg::POS_W-1:0]    rsp_position;
  logic                          rsp_last;
  logic                          out_free;
  logic                          rsp_load;

  logic                          accept;
  logic                          bad_reserve;
  logic                          fits;
  logic [PIDX_W-1:0]             pos_low;
  logic [PEXT_W-1:0]             held_pos_ext;
  logic [SLOTS-1:0]              rel_mask;
  logic [SLOTS-1:0]              grant_mask;
  logic [QIDX_W-1:0]             head_inc;
  logic [QIDX_W-1:0]             tail_inc;

  assign req.ready    = (state == ST_IDLE);
  assign accept       = req.valid && req.ready;
  assign out_free     = !rsp_valid || rsp.ready;

  // The output register takes a new result from FLUSH, or from FIND when a release
  // grants another request and the held result goes out ahead of it.
  assign rsp_load     = out_free &&
                        ((state == ST_FLUSH) || ((state == ST_FIND) && is_rel && fits));

  assign rsp.valid    = rsp_valid;
  assign rsp.kind     = rsp_kind;
  assign rsp.ticket   = rsp_ticket;
  assign rsp.position = rsp_position;
  assign rsp.last     = rsp_last;

  // A reserve is turned away for a size of zero, a size beyond the pool or a full queue.
  assign bad_reserve = (req.count == '0) || (32'(req.count) > 32'(SLOTS)) ||
                       (32'(fill) >= 32'(QDEPTH));

  assign head_inc = (32'(head) == 32'(QDEPTH - 1)) ? '0 : head + QIDX_W'(1);
  assign tail_inc = (32'(tail) == 32'(QDEPTH - 1)) ? '0 : tail + QIDX_W'(1);

  assign win_shift    = len & ~({CNT_W{1'b1}} << step);
  assign pw_shift     = CNT_W'(1) << step;
  assign held_pos_ext = PEXT_W'(held_pos);

  // The lowest start among the windows that fit.
  always_comb begin
    pos_low = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (win[i]) begin
        pos_low = PIDX_W'(i);
      end
    end
  end

  assign fits = |win;

  // Slots freed by a release, clipped at the end of the pool, and slots taken by a grant.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      rel_mask[i]   = (32'(i) >= 32'(req.start_req)) &&
                      (32'(i) < 32'(req.start_req) + 32'(req.count));
      grant_mask[i] = (32'(i) >= 32'(pos_low)) &&
                      (32'(i) < 32'(pos_low) + 32'(len));
    end
  end

  // The size memory is written when a reserve joins the queue and read when the
  // sequencer looks at the head; the two never fall in the same cycle.
  assign size_we = accept && (req.func == fcsa_pkg::FUNC_RESERVE) && !bad_reserve;
  assign size_re = (state == ST_CHECK);

  always_ff @(posedge clk) begin
    if (size_we) begin
      wait_sizes[tail] <= req.count;
    end
    if (size_re) begin
      size_rdata <= wait_sizes[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      occ           <= '0;
      head          <= '0;
      tail          <= '0;
      fill          <= '0;
      next_ticket   <= '0;
      served_ticket <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.func == fcsa_pkg::FUNC_RELEASE) begin
              occ         <= occ & ~rel_mask;
              is_rel      <= 1'b1;
              held_kind   <= fcsa_pkg::KIND_RELEASED;
              held_ticket <= '0;
              held_pos    <= '0;
              state       <= ST_CHECK;
            end else if (bad_reserve) begin
              held_kind   <= fcsa_pkg::KIND_REJECTED;
              held_ticket <= next_ticket;
              held_pos    <= '0;
              state       <= ST_FLUSH;
            end else begin
              tail        <= tail_inc;
              fill        <= fill + FILL_W'(1);
              mine        <= next_ticket;
              next_ticket <= next_ticket + fcsa_pkg::TICKET_W'(1);
              is_rel      <= 1'b0;
              state       <= ST_CHECK;
            end
          end
        end

        ST_CHECK: begin
          // An empty queue ends a release; a reserve always finds its own entry.
          if (fill == '0) begin
            state <= ST_FLUSH;
          end else begin
            state <= ST_LOAD;
          end
        end

        ST_LOAD: begin
          len   <= size_rdata;
          win   <= '1;
          pw    <= ~occ;
          step  <= '0;
          state <= ST_SCAN;
        end

        ST_SCAN: begin
          if (len[step]) begin
            win <= win & (pw >> win_shift);
          end
          pw <= pw & (pw >> pw_shift);
          if (32'(step) == 32'(CNT_W - 1)) begin
            state <= ST_FIND;
          end else begin
            step <= step + STEP_W'(1);
          end
        end

        ST_FIND: begin
          if (!is_rel) begin
            // A reserve gives exactly one result: a grant of the head or a queued notice.
            if (fits) begin
              occ           <= occ | grant_mask;
              head          <= head_inc;
              fill          <= fill - FILL_W'(1);
              served_ticket <= served_ticket + fcsa_pkg::TICKET_W'(1);
              held_kind     <= fcsa_pkg::KIND_GRANT;
              held_ticket   <= served_ticket;
              held_pos      <= pos_low;
            end else begin
              held_kind   <= fcsa_pkg::KIND_QUEUED;
              held_ticket <= mine;
              held_pos    <= '0;
            end
            state <= ST_FLUSH;
          end else if (!fits) begin
            state <= ST_FLUSH;
          end else if (out_free) begin
            // Another grant follows, so the held result goes out as not last.
            rsp_valid     <= 1'b1;
            rsp_kind      <= held_kind;
            rsp_ticket    <= held_ticket;
            rsp_position  <= held_pos_ext[fcsa_pkg::POS_W-1:0];
            rsp_last      <= 1'b0;
            occ           <= occ | grant_mask;
            head          <= head_inc;
            fill          <= fill - FILL_W'(1);
            served_ticket <= served_ticket + fcsa_pkg::TICKET_W'(1);
            held_kind     <= fcsa_pkg::KIND_GRANT;
            held_ticket   <= served_ticket;
            held_pos      <= pos_low;
            state         <= ST_CHECK;
          end
        end

        ST_FLUSH: begin
          if (out_free) begin
            rsp_valid    <= 1'b1;
            rsp_kind     <= held_kind;
            rsp_ticket   <= held_ticket;
            rsp_position <= held_pos_ext[fcsa_pkg::POS_W-1:0];
            rsp_last     <= 1'b1;
            state        <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/fcsa_checker.sv =====
`include "assert_macros.svh"

module fcsa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [1:0]                    rsp_kind,
  input logic [fcsa_pkg::TICKET_W-1:0] rsp_ticket,
  input logic [fcsa_pkg::POS_W-1:0]    rsp_position,
  input logic                          rsp_last
);

  // A stalled result stays offered and unchanged.
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_ticket) && $stable(rsp_position) && $stable(rsp_last))

  // A reserve that is not granted gives a single result, which must close the request.
  `ASSERT_IMPL(a_single_last, clk, rst, rsp_valid && (rsp_kind == fcsa_pkg::KIND_QUEUED || rsp_kind == fcsa_pkg::KIND_REJECTED), rsp_last)

  // Only grants carry a slot position.
  `ASSERT_IMPL(a_pos_zero, clk, rst, rsp_valid && rsp_kind != fcsa_pkg::KIND_GRANT, rsp_position == '0)

  // A release notice carries no ticket.
  `ASSERT_IMPL(a_rel_ticket, clk, rst, rsp_valid && rsp_kind == fcsa_pkg::KIND_RELEASED, rsp_ticket == '0)

endmodule

bind fifo_contiguous_slot_allocator_top fcsa_checker u_fcsa_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_kind     (rsp.kind),
  .rsp_ticket   (rsp.ticket),
  .rsp_position (rsp.position),
  .rsp_last     (rsp.last)
);
